// File: rtl/jtsg_pkg.sv
`timescale 1ns / 1ps
package jtsg_pkg;

    localparam int VW       = 32;
    localparam int FB       = 16;
    localparam int DEADBAND = ((1 << FB) + 9999) / 10000;
    localparam int AW       = 5;

    localparam logic [2:0] REG_STEP_PERIOD     = 3'd0;
    localparam logic [2:0] REG_SPEED_LIMIT     = 3'd1;
    localparam logic [2:0] REG_ACCEL_LIMIT     = 3'd2;
    localparam logic [2:0] REG_GOAL_STEP_LIMIT = 3'd3;
    localparam logic [2:0] REG_RUNAWAY_SPEED   = 3'd4;
    localparam logic [2:0] REG_RUNAWAY_TICKS   = 3'd5;
    localparam logic [2:0] REG_SMOOTH_ENABLE   = 3'd6;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_HOLD = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [VW-1:0] position;
        logic signed [VW-1:0] measured_speed;
    } in_item_t;

    typedef struct packed {
        logic signed [VW-1:0] cmd_position;
        logic signed [VW-1:0] cmd_speed;
        logic signed [VW-1:0] goal;
        logic                 active;
        logic                 goal_clamped;
        logic                 runaway_locked;
    } out_item_t;

    typedef struct packed {
        logic [15:0] step_period;
        logic [30:0] speed_limit;
        logic [30:0] accel_limit;
        logic [30:0] goal_step_limit;
        logic [30:0] runaway_speed;
        logic [7:0]  runaway_ticks;
        logic        smooth_enable;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL_T,
        ST_ROOT,
        ST_MUL_DV,
        ST_APPLY_DV,
        ST_MUL_POS,
        ST_APPLY_POS,
        ST_FIN
    } state_t;

    function automatic logic signed [VW-1:0] sat_v(input logic signed [VW+1:0] v);
        logic signed [VW+1:0] hi;
        logic signed [VW+1:0] lo;
        hi = {3'b000, {(VW-1){1'b1}}};
        lo = {3'b111, {(VW-1){1'b0}}};
        if (v > hi)
            return hi[VW-1:0];
        else if (v < lo)
            return lo[VW-1:0];
        return v[VW-1:0];
    endfunction

    // x*dt / 2^16, nearest, ties away from zero
    function automatic logic signed [VW+1:0] round_dt(input logic signed [48:0] p);
        logic [48:0] mag;
        logic [48:0] q;
        mag = p[48] ? 49'(-p) : 49'(p);
        q   = (mag + 49'd32768) >> 16;
        return p[48] ? -($signed(q[VW+1:0])) : $signed(q[VW+1:0]);
    endfunction

endpackage

// File: rtl/jtsg_regs.sv
`timescale 1ns / 1ps
module jtsg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output jtsg_pkg::cfg_t       cfg
);
    import jtsg_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_period     <= 16'd655;
            cfg_reg.speed_limit     <= 31'd26214;
            cfg_reg.accel_limit     <= 31'd98304;
            cfg_reg.goal_step_limit <= 31'd32768;
            cfg_reg.runaway_speed   <= 31'd131072;
            cfg_reg.runaway_ticks   <= 8'd5;
            cfg_reg.smooth_enable   <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_STEP_PERIOD:     cfg_reg.step_period     <= pwdata[15:0];
                REG_SPEED_LIMIT:     cfg_reg.speed_limit     <= pwdata[30:0];
                REG_ACCEL_LIMIT:     cfg_reg.accel_limit     <= pwdata[30:0];
                REG_GOAL_STEP_LIMIT: cfg_reg.goal_step_limit <= pwdata[30:0];
                REG_RUNAWAY_SPEED:   cfg_reg.runaway_speed   <= pwdata[30:0];
                REG_RUNAWAY_TICKS:   cfg_reg.runaway_ticks   <= pwdata[7:0];
                REG_SMOOTH_ENABLE:   cfg_reg.smooth_enable   <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STEP_PERIOD:     prdata = {16'd0, cfg_reg.step_period};
            REG_SPEED_LIMIT:     prdata = {1'b0, cfg_reg.speed_limit};
            REG_ACCEL_LIMIT:     prdata = {1'b0, cfg_reg.accel_limit};
            REG_GOAL_STEP_LIMIT: prdata = {1'b0, cfg_reg.goal_step_limit};
            REG_RUNAWAY_SPEED:   prdata = {1'b0, cfg_reg.runaway_speed};
            REG_RUNAWAY_TICKS:   prdata = {24'd0, cfg_reg.runaway_ticks};
            REG_SMOOTH_ENABLE:   prdata = {31'd0, cfg_reg.smooth_enable};
            default:             prdata = 32'd0;
        endcase
    end
endmodule

// File: rtl/jtsg_mul.sv
`timescale 1ns / 1ps
module jtsg_mul (
    input  logic               clk,
    input  logic               load,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic signed [67:0] prod
);
    logic signed [67:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= a * b;
    end
endmodule

// File: rtl/jtsg_core.sv
`timescale 1ns / 1ps
module jtsg_core (
    input  logic                clk,
    input  logic                rst_n,
    input  jtsg_pkg::cfg_t      cfg,
    input  logic                item_valid,
    output logic                item_stall,
    input  jtsg_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output jtsg_pkg::out_item_t result
);
    import jtsg_pkg::*;

    state_t               st_reg, st_next;
    logic [1:0]           op_reg;
    logic signed [VW-1:0] pin_reg, ms_reg;
    logic signed [VW-1:0] goal_reg, goal_next;
    logic signed [VW-1:0] pos_reg, pos_next;
    logic signed [VW-1:0] spd_reg, spd_next;
    logic                 act_reg, act_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic                 up_reg, up_next;
    logic                 chk_reg, chk_next;
    logic                 clamp_reg, clamp_next;
    logic [32:0]          mag_reg, mag_next;
    logic [30:0]          root_reg, root_next;
    logic [63:0]          sq_reg, sq_next;
    logic [4:0]           bit_reg, bit_next;
    out_item_t            res_reg, res_next;
    logic                 rv_reg, rv_next;

    logic                 mul_load;
    logic signed [33:0]   mul_a, mul_b;
    logic signed [67:0]   prod;

    logic                 accept, fin_go;
    logic signed [VW+1:0] err, delta, lim, gsum, dvmax, desired, dv, left;
    logic [30:0]          cand;
    logic [63:0]          sq_cand;
    logic [64:0]          t_root;
    logic                 take;
    logic signed [VW-1:0] posf, spdf;
    logic [32:0]          ms_mag;
    logic [7:0]           cnt_inc;
    logic                 over, lock;

    jtsg_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign accept       = (st_reg == ST_IDLE) && item_valid;
    assign fin_go       = (st_reg == ST_FIN) && !(rv_reg && result_stall);
    assign item_stall   = (st_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // arithmetic shared by the states
    always_comb
    begin
        err     = {{2{goal_reg[VW-1]}}, goal_reg} - {{2{pos_reg[VW-1]}}, pos_reg};
        delta   = {{2{pin_reg[VW-1]}}, pin_reg} - {{2{goal_reg[VW-1]}}, goal_reg};
        lim     = {3'b000, cfg.goal_step_limit};
        cand    = root_reg | (31'd1 << bit_reg);
        sq_cand = sq_reg + ({33'd0, root_reg} << ({1'b0, bit_reg} + 6'd1))
                  + (64'd1 << {bit_reg, 1'b0});
        t_root  = {prod[63:0], 1'b0};
        take    = (cand <= cfg.speed_limit) && ({1'b0, sq_cand} <= t_root);
        dvmax   = round_dt(prod[48:0]);
        desired = up_reg ? {3'b000, root_reg} : -{3'b000, root_reg};
        dv      = desired - {{2{spd_reg[VW-1]}}, spd_reg};
        left    = {{2{goal_reg[VW-1]}}, goal_reg} - {{2{pos_reg[VW-1]}}, pos_reg};
        ms_mag  = ms_reg[VW-1] ? 33'(-{ms_reg[VW-1], ms_reg}) : {1'b0, ms_reg};
        cnt_inc = (cnt_reg == 8'hFF) ? cnt_reg : cnt_reg + 8'd1;
        if (delta > lim)
            gsum = {{2{goal_reg[VW-1]}}, goal_reg} + lim;
        else
            gsum = {{2{goal_reg[VW-1]}}, goal_reg} - lim;
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:      if (item_valid) st_next = ST_EXEC;
            ST_EXEC:
            begin
                if (op_reg == OP_TICK && cfg.smooth_enable && cfg.step_period != 16'd0
                    && !(err < 34'(DEADBAND) && err > -34'(DEADBAND)))
                    st_next = ST_MUL_T;
                else
                    st_next = ST_FIN;
            end
            ST_MUL_T:     st_next = ST_ROOT;
            ST_ROOT:      if (bit_reg == 5'd0) st_next = ST_MUL_DV;
            ST_MUL_DV:    st_next = ST_APPLY_DV;
            ST_APPLY_DV:  st_next = ST_MUL_POS;
            ST_MUL_POS:   st_next = ST_APPLY_POS;
            ST_APPLY_POS: st_next = ST_FIN;
            ST_FIN:       if (fin_go) st_next = ST_IDLE;
            default:      st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        goal_next  = goal_reg;
        pos_next   = pos_reg;
        spd_next   = spd_reg;
        act_next   = act_reg;
        cnt_next   = cnt_reg;
        up_next    = up_reg;
        chk_next   = chk_reg;
        clamp_next = clamp_reg;
        mag_next   = mag_reg;
        root_next  = root_reg;
        sq_next    = sq_reg;
        bit_next   = bit_reg;
        res_next   = res_reg;
        rv_next    = rv_reg && result_stall;
        mul_load   = 1'b0;
        mul_a      = {3'b000, cfg.accel_limit};
        mul_b      = {1'b0, mag_reg};
        posf       = pos_reg;
        spdf       = spd_reg;
        over       = 1'b0;
        lock       = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                clamp_next = 1'b0;
                chk_next   = 1'b0;
            end
            ST_EXEC:
            begin
                mag_next = err[VW+1] ? 33'(-err) : err[32:0];
                up_next  = !err[VW+1];
                chk_next = 1'b1;
                unique case (op_reg)
                    OP_CMD:
                    begin
                        act_next = 1'b1;
                        if (delta > lim || delta < -lim)
                        begin
                            clamp_next = 1'b1;
                            goal_next  = sat_v(gsum);
                        end
                        else
                            goal_next = pin_reg;
                    end
                    OP_HOLD:
                    begin
                        goal_next = pin_reg;
                        pos_next  = pin_reg;
                        spd_next  = '0;
                        act_next  = 1'b0;
                    end
                    OP_TICK:
                    begin
                        if (!cfg.smooth_enable ||
                            (cfg.step_period != 16'd0 &&
                             err < 34'(DEADBAND) && err > -34'(DEADBAND)))
                        begin
                            pos_next = goal_reg;
                            spd_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MUL_T:
            begin
                mul_load  = 1'b1;
                root_next = '0;
                sq_next   = '0;
                bit_next  = 5'd30;
            end
            ST_ROOT:
            begin
                if (take)
                begin
                    root_next = cand;
                    sq_next   = sq_cand;
                end
                bit_next = bit_reg - 5'd1;
            end
            ST_MUL_DV:
            begin
                mul_load = 1'b1;
                mul_b    = {18'd0, cfg.step_period};
            end
            ST_APPLY_DV:
            begin
                if (dv > dvmax)
                    spd_next = sat_v({{2{spd_reg[VW-1]}}, spd_reg} + dvmax);
                else if (dv < -dvmax)
                    spd_next = sat_v({{2{spd_reg[VW-1]}}, spd_reg} - dvmax);
                else
                    spd_next = sat_v({{2{spd_reg[VW-1]}}, spd_reg} + dv);
            end
            ST_MUL_POS:
            begin
                mul_load = 1'b1;
                mul_a    = {{2{spd_reg[VW-1]}}, spd_reg};
                mul_b    = {18'd0, cfg.step_period};
            end
            ST_APPLY_POS:
            begin
                pos_next = sat_v({{2{pos_reg[VW-1]}}, pos_reg} + dvmax);
                chk_next = 1'b1;
            end
            ST_FIN:
            begin
                // overshoot snap only after a real profile step
                if (chk_reg && op_reg == OP_TICK && st_reg == ST_FIN &&
                    (up_reg ? left <= 34'sd0 : left >= 34'sd0) && cfg.smooth_enable
                    && cfg.step_period != 16'd0 && mag_reg >= 33'(DEADBAND))
                begin
                    posf = goal_reg;
                    spdf = '0;
                end
                res_next.cmd_position   = posf;
                res_next.cmd_speed      = spdf;
                res_next.goal           = goal_reg;
                res_next.active         = act_reg;
                res_next.goal_clamped   = clamp_reg;
                res_next.runaway_locked = 1'b0;
                if (op_reg == OP_TICK)
                begin
                    over = !act_reg && (ms_mag > {2'b00, cfg.runaway_speed});
                    lock = over && (cnt_inc >= cfg.runaway_ticks);
                    res_next.runaway_locked = lock;
                    if (lock)
                        res_next.goal = pin_reg;
                end
                if (fin_go)
                begin
                    rv_next  = 1'b1;
                    pos_next = posf;
                    spd_next = spdf;
                    if (op_reg == OP_TICK)
                        cnt_next = over ? cnt_inc : 8'd0;
                    if (lock)
                    begin
                        goal_next = pin_reg;
                        pos_next  = pin_reg;
                        spd_next  = '0;
                        act_next  = 1'b0;
                        cnt_next  = 8'd0;
                    end
                end
                else
                    res_next = res_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            goal_reg <= '0;
            pos_reg  <= '0;
            spd_reg  <= '0;
            act_reg  <= 1'b0;
            cnt_reg  <= 8'd0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            goal_reg <= goal_next;
            pos_reg  <= pos_next;
            spd_reg  <= spd_next;
            act_reg  <= act_next;
            cnt_reg  <= cnt_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= item.op;
            pin_reg <= item.position;
            ms_reg  <= item.measured_speed;
        end
        up_reg    <= up_next;
        chk_reg   <= chk_next;
        clamp_reg <= clamp_next;
        mag_reg   <= mag_next;
        root_reg  <= root_next;
        sq_reg    <= sq_next;
        bit_reg   <= bit_next;
        res_reg   <= res_next;
    end

    a_root_sq: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ROOT) |-> (sq_reg == 64'(root_reg) * 64'(root_reg)))
        else $error("root square tracking broken");

    a_root_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_MUL_DV) |-> (root_reg <= cfg.speed_limit))
        else $error("root above speed limit");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rv_reg) |-> $past(st_reg) == ST_FIN)
        else $error("result raised outside final state");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> item_stall)
        else $error("input open while busy");
endmodule

// File: rtl/joint_trapezoid_setpoint_generator.sv
`timescale 1ns / 1ps
// channel   | handshake                       | payload
// ----------+---------------------------------+---------------------------------------
// item      | item_valid / item_stall         | op, position, measured_speed
// result    | result_valid / result_stall     | cmd_position, cmd_speed, goal, flags
// cfg       | psel, penable, pwrite, pready   | paddr 4*i, pwdata / prdata 32 bit
//
// Command, hold, and smoothing-off, zero-step-period or deadband ticks pass from
// accept through the execute state to the final state. A profile tick also runs
// the bit-serial root loop and three passes through the shared 34x34 multiplier.
// Reset (rst_n low, async) clears profile state and loads register defaults.
// The result sits in an output register; a stalled result holds the block in
// its final state, and item_stall is high whenever the sequencer is busy.
module joint_trapezoid_setpoint_generator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  jtsg_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output jtsg_pkg::out_item_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import jtsg_pkg::*;

    cfg_t cfg;

    // register file on the config port
    jtsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer plus datapath around the shared multiplier
    jtsg_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );
endmodule
